FILE: rtl/dbs_pkg.sv
`default_nettype none
package dbs_pkg;

	localparam int TEMP_W     = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EMPTY_LEVEL   = 3'd0,
		CFG_PRESENT_LEVEL = 3'd1,
		CFG_GRACE_TICKS   = 3'd2,
		CFG_ARM_TICKS     = 3'd3,
		CFG_OVER_TEMP     = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ALARM_NONE  = 2'd0,
		ALARM_SLOW  = 2'd1,
		ALARM_RAPID = 2'd2
	} alarm_t;

	typedef struct packed {
		logic   drive_one;
		logic   drive_two;
		logic   armed_state;
		alarm_t alarm_request;
		logic   dual_low_event;
		logic   hot_one_event;
		logic   hot_two_event;
		logic   present_one;
		logic   present_two;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/dbs_cfg.sv
`default_nettype none
module dbs_cfg #(
	parameter int LEVEL_BITS = 10,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [dbs_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [dbs_pkg::CFG_DATA_W-1:0]   wr_data,
	output logic      [LEVEL_BITS-1:0]            empty_level,
	output logic      [LEVEL_BITS-1:0]            present_level,
	output logic      [COUNT_BITS-1:0]            grace_ticks,
	output logic      [COUNT_BITS-1:0]            arm_ticks,
	output logic signed [dbs_pkg::TEMP_W-1:0]     over_temp_limit
);
	import dbs_pkg::*;

	logic [LEVEL_BITS-1:0]    empty_q;
	logic [LEVEL_BITS-1:0]    present_q;
	logic [COUNT_BITS-1:0]    grace_q;
	logic [COUNT_BITS-1:0]    arm_q;
	logic signed [TEMP_W-1:0] otemp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q   <= LEVEL_BITS'(756);
			present_q <= LEVEL_BITS'(27);
			grace_q   <= COUNT_BITS'(1000);
			arm_q     <= COUNT_BITS'(500);
			otemp_q   <= TEMP_W'(480);
		end else if (wr_en) begin
			case (wr_index)
				CFG_EMPTY_LEVEL:   empty_q   <= wr_data[LEVEL_BITS-1:0];
				CFG_PRESENT_LEVEL: present_q <= wr_data[LEVEL_BITS-1:0];
				CFG_GRACE_TICKS:   grace_q   <= wr_data[COUNT_BITS-1:0];
				CFG_ARM_TICKS:     arm_q     <= wr_data[COUNT_BITS-1:0];
				CFG_OVER_TEMP:     otemp_q   <= wr_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	assign empty_level     = empty_q;
	assign present_level   = present_q;
	assign grace_ticks     = grace_q;
	assign arm_ticks       = arm_q;
	assign over_temp_limit = otemp_q;

endmodule
`default_nettype wire

FILE: rtl/dbs_core.sv
`default_nettype none
module dbs_core #(
	parameter int LEVEL_BITS = 10,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step_en,
	input  wire logic [LEVEL_BITS-1:0]         level_one,
	input  wire logic [LEVEL_BITS-1:0]         level_two,
	input  wire logic                          arm_line,
	input  wire logic signed [dbs_pkg::TEMP_W-1:0] temp_one,
	input  wire logic signed [dbs_pkg::TEMP_W-1:0] temp_two,
	input  wire logic [LEVEL_BITS-1:0]         empty_level,
	input  wire logic [LEVEL_BITS-1:0]         present_level,
	input  wire logic [COUNT_BITS-1:0]         grace_ticks,
	input  wire logic [COUNT_BITS-1:0]         arm_ticks,
	input  wire logic signed [dbs_pkg::TEMP_W-1:0] over_temp_limit,
	output dbs_pkg::result_t                   res
);
	import dbs_pkg::*;

	logic                  on1_q, on2_q, armed_q, dl_seen_q, hot1_seen_q, hot2_seen_q;
	logic [COUNT_BITS-1:0] arm_cnt_q, since_q;

	logic                  on1_d, on2_d, armed_d, dl_seen_d, hot1_seen_d, hot2_seen_d;
	logic [COUNT_BITS-1:0] arm_cnt_d, since_d;
	logic [COUNT_BITS:0]   elapsed;
	logic                  sample, pres1, pres2, empty1, empty2, in_grace, switched;
	logic                  dl_now, hot1_now, hot2_now;
	alarm_t                alarm;

	always_comb begin
		pres1    = level_one >= present_level;
		pres2    = level_two >= present_level;
		empty1   = level_one < empty_level;
		empty2   = level_two < empty_level;
		in_grace = since_q < grace_ticks;

		elapsed   = (COUNT_BITS+1)'(arm_cnt_q) + (COUNT_BITS+1)'(1);
		sample    = elapsed > (COUNT_BITS+1)'(arm_ticks);
		armed_d   = sample ? arm_line : armed_q;
		arm_cnt_d = sample ? '0 : elapsed[COUNT_BITS-1:0];

		on1_d    = armed_d & on1_q;
		on2_d    = armed_d & on2_q;
		switched = 1'b0;
		alarm    = ALARM_NONE;

		if (!in_grace && armed_d) begin
			if (on1_d && on2_d) begin
				if (!empty1) begin
					on2_d    = 1'b0;
					switched = 1'b1;
				end
				if (!empty2) begin
					on1_d    = 1'b0;
					switched = 1'b1;
				end
			end
			if (!on1_d && !on2_d) begin
				if (level_one > level_two) on1_d = 1'b1;
				else on2_d = 1'b1;
			end
			if (on1_d && empty1 && pres2 && !on2_d) begin
				on2_d    = 1'b1;
				switched = 1'b1;
				if (!empty2) begin
					on1_d = 1'b0;
					alarm = ALARM_SLOW;
				end else begin
					alarm = ALARM_RAPID;
				end
			end
			if (on2_d && empty2 && pres1 && !on1_d) begin
				on1_d    = 1'b1;
				switched = 1'b1;
				if (!empty1) begin
					on2_d = 1'b0;
					alarm = ALARM_SLOW;
				end else begin
					alarm = ALARM_RAPID;
				end
			end
		end

		if (switched) since_d = '0;
		else if (!in_grace) since_d = grace_ticks;
		else since_d = since_q + COUNT_BITS'(1);

		dl_now      = pres1 && empty1 && pres2 && empty2;
		dl_seen_d   = dl_now;
		hot1_now    = temp_one > over_temp_limit;
		hot2_now    = temp_two > over_temp_limit;
		hot1_seen_d = hot1_now;
		hot2_seen_d = hot2_now;
		if ((hot1_now && !hot1_seen_q) || (hot2_now && !hot2_seen_q)) alarm = ALARM_RAPID;

		res.drive_one      = on1_d;
		res.drive_two      = on2_d;
		res.armed_state    = armed_d;
		res.alarm_request  = alarm;
		res.dual_low_event = dl_now && !dl_seen_q;
		res.hot_one_event  = hot1_now && !hot1_seen_q;
		res.hot_two_event  = hot2_now && !hot2_seen_q;
		res.present_one    = pres1;
		res.present_two    = pres2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on1_q       <= 1'b0;
			on2_q       <= 1'b0;
			armed_q     <= 1'b0;
			arm_cnt_q   <= '0;
			since_q     <= '0;
			dl_seen_q   <= 1'b0;
			hot1_seen_q <= 1'b0;
			hot2_seen_q <= 1'b0;
		end else if (step_en) begin
			on1_q       <= on1_d;
			on2_q       <= on2_d;
			armed_q     <= armed_d;
			arm_cnt_q   <= arm_cnt_d;
			since_q     <= since_d;
			dl_seen_q   <= dl_seen_d;
			hot1_seen_q <= hot1_seen_d;
			hot2_seen_q <= hot2_seen_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dual_battery_selector_top.sv
// Dual battery selector.
// Input channel (in_valid/in_ready): one request per sensor tick carrying both
// battery codes, the arming line and two temperatures. Output channel
// (out_valid/out_ready): one result per request with switch states, armed
// state, alarm request, edge events and presence flags.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the five
// threshold/timing registers; cfg_ready is always high. Write only while idle.
// A request is captured in the input register; its result is captured in the
// result register when it advances. One request per cycle while out_ready is
// high; the state update is one pass of compare/count logic between the input
// register and the result register. Reset clears both switches, the arming
// state, all counters and edge flags, and loads register defaults. While a result
// waits with out_ready low the result register holds; the input register still
// takes one more request, then in_ready drops until the result is taken.
`default_nettype none
module dual_battery_selector_top #(
	parameter int LEVEL_BITS = 10,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [LEVEL_BITS-1:0]             level_one,
	input  wire logic [LEVEL_BITS-1:0]             level_two,
	input  wire logic                              arm_line,
	input  wire logic signed [dbs_pkg::TEMP_W-1:0] temp_one,
	input  wire logic signed [dbs_pkg::TEMP_W-1:0] temp_two,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   drive_one,
	output logic                                   drive_two,
	output logic                                   armed_state,
	output logic [1:0]                             alarm_request,
	output logic                                   dual_low_event,
	output logic                                   hot_one_event,
	output logic                                   hot_two_event,
	output logic                                   present_one,
	output logic                                   present_two,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [dbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dbs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dbs_pkg::*;

	logic                     valid_s1;
	logic [LEVEL_BITS-1:0]    level_one_s1, level_two_s1;
	logic                     arm_line_s1;
	logic signed [TEMP_W-1:0] temp_one_s1, temp_two_s1;

	logic                     out_valid_q;
	result_t                  result_q;
	result_t                  res;

	logic                     out_free, adv, accept;

	logic [LEVEL_BITS-1:0]    empty_level, present_level;
	logic [COUNT_BITS-1:0]    grace_ticks, arm_ticks;
	logic signed [TEMP_W-1:0] over_temp_limit;

	assign out_free  = !out_valid_q || out_ready;
	assign adv       = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	dbs_cfg #(
		.LEVEL_BITS(LEVEL_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (cfg_valid && cfg_ready),
		.wr_index       (cfg_index),
		.wr_data        (cfg_data),
		.empty_level    (empty_level),
		.present_level  (present_level),
		.grace_ticks    (grace_ticks),
		.arm_ticks      (arm_ticks),
		.over_temp_limit(over_temp_limit)
	);

	dbs_core #(
		.LEVEL_BITS(LEVEL_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (adv),
		.level_one      (level_one_s1),
		.level_two      (level_two_s1),
		.arm_line       (arm_line_s1),
		.temp_one       (temp_one_s1),
		.temp_two       (temp_two_s1),
		.empty_level    (empty_level),
		.present_level  (present_level),
		.grace_ticks    (grace_ticks),
		.arm_ticks      (arm_ticks),
		.over_temp_limit(over_temp_limit),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_one_s1 <= level_one;
			level_two_s1 <= level_two;
			arm_line_s1  <= arm_line;
			temp_one_s1  <= temp_one;
			temp_two_s1  <= temp_two;
		end
		if (adv) result_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign drive_one      = result_q.drive_one;
	assign drive_two      = result_q.drive_two;
	assign armed_state    = result_q.armed_state;
	assign alarm_request  = result_q.alarm_request;
	assign dual_low_event = result_q.dual_low_event;
	assign hot_one_event  = result_q.hot_one_event;
	assign hot_two_event  = result_q.hot_two_event;
	assign present_one    = result_q.present_one;
	assign present_two    = result_q.present_two;

	a_disarmed_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !armed_state |-> !drive_one && !drive_two)
		else $error("switch on while disarmed");

	a_hot_rapid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (hot_one_event || hot_two_event) |-> alarm_request == ALARM_RAPID)
		else $error("over-temperature without rapid alarm");

	a_slow_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alarm_request == ALARM_SLOW |-> drive_one != drive_two)
		else $error("slow alarm with both switches equal");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

endmodule
`default_nettype wire
